// File: rtl/core/brb_pkg.sv
// shared types and constants for the byte ring buffer with bulk transfers
package brb_pkg;

    // fixed field widths
    localparam int CNT_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int ACT_W       = 2;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    // capacity after reset
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    // item kinds on s_tuser
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK  = 2'd2;

    // result status codes
    localparam logic STAT_OK     = 1'b0;
    localparam logic STAT_REJECT = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic take_item;   // input item accepted this cycle
        logic emit_byte;   // move the fetched byte into the output register
    } brb_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;    // output register can load this cycle
        logic req_ok;      // current input is a read or peek that will stream
        logic stream_last; // byte being emitted is the last of the request
    } brb_sts_t;

endpackage

// File: rtl/core/brb_ram.sv
// generic single write port, single read port RAM with registered read
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read, read data holds while re is low
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/brb_ctrl.sv
// controller state machine: accepts items and sequences read streams
module brb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  brb_pkg::brb_sts_t sts,
    output brb_pkg::brb_cmd_t cmd
);
    import brb_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    state_t state_reg;
    state_t state_next;

    // handshake and commands
    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    cmd.take_item = 1'b1;
                    if (sts.req_ok) begin
                        state_next = ST_STREAM;
                    end
                end
            end
            ST_STREAM: begin
                if (sts.out_free) begin
                    cmd.emit_byte = 1'b1;
                    if (sts.stream_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/brb_datapath.sv
// datapath: pointers, fill count, write tracking, storage and result register
module brb_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [brb_pkg::CNT_W-1:0]           cfg_wdata,
    input  logic [brb_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [brb_pkg::ACT_W-1:0]           s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [brb_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  brb_pkg::brb_cmd_t                   cmd,
    output brb_pkg::brb_sts_t                   sts
);
    import brb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // state registers
    logic [CNT_W-1:0] cap_reg;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] wr_rem_reg, wr_rem_next;
    logic             wr_adm_reg, wr_adm_next;
    logic [CNT_W-1:0] wr_stored_reg, wr_stored_next;

    // stream registers
    logic [PTR_W-1:0] walk_reg, walk_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             is_read_reg, is_read_next;

    // output register
    logic             ov_reg, ov_next;
    logic [BYTE_W-1:0] od_reg, od_next;
    logic             olast_reg, olast_next;
    logic             ostat_reg, ostat_next;
    logic [CNT_W-1:0] ocnt_reg, ocnt_next;
    logic [CNT_W-1:0] ofill_reg, ofill_next;
    logic [CNT_W-1:0] ocap_reg, ocap_next;

    // storage ports
    logic              ram_we, ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // input fields
    logic [ACT_W-1:0]  action;
    logic [CNT_W-1:0]  len_in;
    logic [BYTE_W-1:0] din;
    logic              is_wr, is_rd, is_pk;

    // effective capacity and write bookkeeping
    logic [CNT_W-1:0] cap;
    logic             wr_open, admit, do_store, close;
    logic [CNT_W-1:0] rem, rem_after, stored, stored_after, fill_after;

    // wrap a pointer at the effective capacity
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] n;
        n = CNT_W'(p) + CNT_W'(1);
        return (n >= c) ? '0 : n[PTR_W-1:0];
    endfunction

    assign action = s_tuser;
    assign len_in = s_tdata[CNT_W-1:0];
    assign din    = s_tdata[CNT_W+BYTE_W-1:CNT_W];
    assign is_wr  = (action == ACT_WRITE);
    assign is_rd  = (action == ACT_READ);
    assign is_pk  = (action == ACT_PEEK);

    // clamp capacity into one to depth
    always_comb begin
        if (cap_reg == '0) begin
            cap = CNT_W'(1);
        end else if (cap_reg > DEPTH_C) begin
            cap = DEPTH_C;
        end else begin
            cap = cap_reg;
        end
    end

    // write transaction decode
    always_comb begin
        wr_open      = (wr_rem_reg != '0);
        admit        = wr_open ? wr_adm_reg
                               : ((len_in != '0) && (fill_reg <= cap)
                                  && (len_in <= cap - fill_reg));
        rem          = wr_open ? wr_rem_reg : ((len_in == '0) ? CNT_W'(1) : len_in);
        stored       = wr_open ? wr_stored_reg : '0;
        do_store     = admit && (fill_reg < cap);
        rem_after    = rem - CNT_W'(1);
        close        = s_tlast || (rem_after == '0);
        fill_after   = fill_reg + CNT_W'(do_store);
        stored_after = stored + CNT_W'(do_store);
    end

    // status to controller
    assign sts.out_free    = !ov_reg || m_tready;
    assign sts.req_ok      = (is_rd || is_pk) && (len_in != '0) && (len_in <= fill_reg);
    assign sts.stream_last = ((k_reg + CNT_W'(1)) == len_reg);

    // next state
    always_comb begin
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        wr_rem_next    = wr_rem_reg;
        wr_adm_next    = wr_adm_reg;
        wr_stored_next = wr_stored_reg;
        walk_next      = walk_reg;
        len_next       = len_reg;
        k_next         = k_reg;
        is_read_next   = is_read_reg;
        ov_next        = ov_reg && !m_tready;
        od_next        = od_reg;
        olast_next     = olast_reg;
        ostat_next     = ostat_reg;
        ocnt_next      = ocnt_reg;
        ofill_next     = ofill_reg;
        ocap_next      = ocap_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = rp_reg;

        if (cfg_we) begin
            // capacity write empties the buffer
            rp_next        = '0;
            wp_next        = '0;
            fill_next      = '0;
            wr_rem_next    = '0;
            wr_adm_next    = 1'b0;
            wr_stored_next = '0;
        end else if (cmd.take_item && is_wr) begin
            // write byte
            if (do_store) begin
                ram_we  = 1'b1;
                wp_next = advance(wp_reg, cap);
            end
            fill_next = fill_after;
            if (close) begin
                wr_rem_next    = '0;
                wr_adm_next    = 1'b0;
                wr_stored_next = '0;
                ov_next        = 1'b1;
                od_next        = '0;
                olast_next     = 1'b1;
                ostat_next     = admit ? STAT_OK : STAT_REJECT;
                ocnt_next      = admit ? stored_after : '0;
                ofill_next     = fill_after;
                ocap_next      = cap;
            end else begin
                wr_rem_next    = rem_after;
                wr_adm_next    = admit;
                wr_stored_next = stored_after;
            end
        end else if (cmd.take_item && (is_rd || is_pk)) begin
            if (sts.req_ok) begin
                // start the stream, fetch the first byte
                ram_re       = 1'b1;
                ram_raddr    = rp_reg;
                walk_next    = advance(rp_reg, cap);
                len_next     = len_in;
                k_next       = '0;
                is_read_next = is_rd;
                if (is_rd) begin
                    fill_next = fill_reg - len_in;
                end
            end else begin
                // zero length or not enough data
                ov_next    = 1'b1;
                od_next    = '0;
                olast_next = 1'b1;
                ostat_next = STAT_REJECT;
                ocnt_next  = '0;
                ofill_next = fill_reg;
                ocap_next  = cap;
            end
        end else if (cmd.emit_byte) begin
            // hand out a fetched byte and fetch the next one
            ov_next    = 1'b1;
            od_next    = ram_rdata;
            olast_next = sts.stream_last;
            ostat_next = STAT_OK;
            ocnt_next  = len_reg;
            ofill_next = fill_reg;
            ocap_next  = cap;
            k_next     = k_reg + CNT_W'(1);
            if (sts.stream_last) begin
                if (is_read_reg) begin
                    rp_next = walk_reg;
                end
            end else begin
                ram_re    = 1'b1;
                ram_raddr = walk_reg;
                walk_next = advance(walk_reg, cap);
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            rp_reg        <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            wr_rem_reg    <= '0;
            wr_adm_reg    <= 1'b0;
            wr_stored_reg <= '0;
            ov_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            wr_rem_reg    <= wr_rem_next;
            wr_adm_reg    <= wr_adm_next;
            wr_stored_reg <= wr_stored_next;
            ov_reg        <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        walk_reg    <= walk_next;
        len_reg     <= len_next;
        k_reg       <= k_next;
        is_read_reg <= is_read_next;
        od_reg      <= od_next;
        olast_reg   <= olast_next;
        ostat_reg   <= ostat_next;
        ocnt_reg    <= ocnt_next;
        ofill_reg   <= ofill_next;
        ocap_reg    <= ocap_next;
    end

    // byte storage
    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (din),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result port
    assign m_tvalid = ov_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = ostat_reg;
    assign m_tdata  = {(ofill_reg == ocap_reg), (ofill_reg == '0),
                       ofill_reg, ocnt_reg, od_reg};

endmodule

// File: rtl/core/byte_ring_buffer_bulk_core.sv
// top level of the byte ring buffer with all-or-nothing bulk transfers
// write bytes: one item per cycle while the result port is free, status result in the cycle after the closing byte
// read or peek of length L: first byte via the registered storage read and the output register,
//   then one byte per cycle while m_tready is high, paced by the storage read feeding that register
// reject results appear in the cycle after the request; no new item during a stream
// aresetn (synchronous, active low) empties the buffer and sets capacity to 64
module byte_ring_buffer_bulk_core #(
    parameter int DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // capacity register
    input  logic                                cfg_we,
    input  logic [brb_pkg::CNT_W-1:0]           cfg_wdata,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [brb_pkg::S_TDATA_W-1:0]       s_tdata,  // length[6:0], data_in[14:7], pad
    input  logic [brb_pkg::ACT_W-1:0]           s_tuser,  // action[1:0]
    input  logic                                s_tlast,  // last_in
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [brb_pkg::M_TDATA_W-1:0]       m_tdata,  // data_out[7:0], count[14:8],
                                                          // fill_level[21:15],
                                                          // is_empty[22], is_full[23]
    output logic                                m_tuser,  // status
    output logic                                m_tlast   // last_out
);
    import brb_pkg::*;

    brb_cmd_t cmd;
    brb_sts_t sts;

    // sequencing
    brb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // buffer state and results
    brb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
